// File: src/wtok_pkg.sv
`default_nettype none
package wtok_pkg;

  // Size of the text space; offsets saturate one below it, and never above 16 bits.
  localparam longint unsigned TEXT_MAX = 64'd65536;
  localparam longint unsigned CAP_WIDE = (TEXT_MAX - 64'd1 > 64'd65535) ?
                                         64'd65535 : TEXT_MAX - 64'd1;
  localparam logic [15:0] OFFSET_CAP = CAP_WIDE[15:0];

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_HIGH  = 8'h80;
  localparam logic [7:0] BYTE_APOS  = 8'h27;

  // Everything one text byte produces: up to a closed word, its apostrophe
  // run and a single-byte token, in that order.
  typedef struct packed {
    logic        word_valid;
    logic [15:0] word_off;
    logic [15:0] word_len;
    logic        run_valid;
    logic [15:0] run_off;
    logic [15:0] run_len;
    logic        single_valid;
    logic [15:0] single_off;
    logic        done;
    logic        ovf;
  } job_t;

endpackage
`default_nettype wire

// File: src/word_tokenizer_core.sv
// Word tokenizer: takes text one byte per transfer and reports each token as a
// kind, an offset and a length. A front stage classifies the byte, tracks the
// open word and builds every result the byte causes (a closed word, its run of
// trailing apostrophes, a single-byte token); a queue of QUEUE_DEPTH entries
// holds these groups, and a back stage sends them out one result per cycle,
// while results wait and out_ready is high, through an output register. A byte
// is taken every cycle while the queue has room, so the input rate is one byte
// per cycle; the output side is bound by its single result register, so a byte
// that causes several results takes one output transfer for each, and the queue
// rides out bursts of tokens. in_ready depends only on the queue fill, never on
// out_ready in the same cycle. The first result of a byte is written to the
// queue and then to the output register before it is presented. run_last marks
// the last result of a byte; bytes that cause no result produce nothing.
`default_nettype none
module word_tokenizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_token_kind,
  output logic [15:0]      out_token_offset,
  output logic [15:0]      out_token_length,
  output logic             out_text_done,
  output logic             out_offset_overflow,
  output logic             out_run_last
);

  // Result groups travel from the classifier to the sequencer as one struct.
  wtok_pkg::job_t push_job, head_job;
  logic           push, q_full, head_valid, pop;

  wtok_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  // The queue decouples the byte stream from result delivery.
  wtok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // The back stage walks the pending results of the head group in order.
  wtok_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_token_offset    (out_token_offset),
    .out_token_length    (out_token_length),
    .out_text_done       (out_text_done),
    .out_offset_overflow (out_offset_overflow),
    .out_run_last        (out_run_last)
  );

endmodule
`default_nettype wire

// File: src/wtok_front.sv
`default_nettype none
module wtok_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic            in_final_byte,
  input  wire logic            q_full,
  output logic                 push,
  output wtok_pkg::job_t       job
);

  logic [15:0] pos_r, pos_nxt;
  logic        in_word_r, in_word_nxt;
  logic [15:0] wb_r, wb_nxt;
  logic [15:0] trail_r, trail_nxt;
  logic        ovf_r, ovf_nxt;

  logic        accept, at_cap, ovf_now;
  logic        is_skip, is_word, is_apos;
  logic        mid_close, open_after, closing, single;
  logic [15:0] begin_after, trail_after;
  logic [16:0] end_w, wb_w, span, tr_lim, tr, wlen, run_off_w;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_skip = (in_text_byte <= wtok_pkg::BYTE_SPACE) || (in_text_byte == wtok_pkg::BYTE_DEL);
    is_word = (in_text_byte inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]}) ||
              (in_text_byte >= wtok_pkg::BYTE_HIGH);
    is_apos = (in_text_byte == wtok_pkg::BYTE_APOS);

    at_cap  = (pos_r >= wtok_pkg::OFFSET_CAP);
    ovf_now = ovf_r || at_cap;

    mid_close  = in_word_r && !is_word && !is_apos;
    open_after = in_word_r ? (is_word || is_apos) : is_word;
    begin_after = in_word_r ? wb_r : pos_r;
    if (!in_word_r || is_word) begin
      trail_after = 16'd0;
    end else if (is_apos && trail_r != 16'hffff) begin
      trail_after = trail_r + 16'd1;
    end else begin
      trail_after = trail_r;
    end
    closing = mid_close || (in_final_byte && open_after);
    single  = !is_skip && !is_word && !(in_word_r && is_apos);

    // A word still open at the final byte ends after it; a word closed by a delimiter ends at this byte.
    end_w  = {1'b0, pos_r} + {16'd0, !mid_close};
    wb_w   = {1'b0, begin_after};
    span   = (end_w > wb_w) ? end_w - wb_w : 17'd1;
    tr_lim = span - 17'd1;
    tr     = ({1'b0, trail_after} > tr_lim) ? tr_lim : {1'b0, trail_after};
    wlen   = span - tr;
    run_off_w = end_w - tr;

    job.word_valid   = closing;
    job.word_off     = begin_after;
    job.word_len     = wlen[16] ? 16'hffff : wlen[15:0];
    job.run_valid    = closing && (tr != 17'd0);
    job.run_off      = run_off_w[15:0];
    job.run_len      = tr[15:0];
    job.single_valid = single;
    job.single_off   = pos_r;
    job.done         = in_final_byte;
    job.ovf          = ovf_now;

    push = accept && (closing || single);

    pos_nxt     = pos_r;
    in_word_nxt = in_word_r;
    wb_nxt      = wb_r;
    trail_nxt   = trail_r;
    ovf_nxt     = ovf_r;
    if (accept) begin
      if (in_final_byte) begin
        pos_nxt     = 16'd0;
        in_word_nxt = 1'b0;
        wb_nxt      = 16'd0;
        trail_nxt   = 16'd0;
        ovf_nxt     = 1'b0;
      end else begin
        pos_nxt     = at_cap ? pos_r : pos_r + 16'd1;
        in_word_nxt = open_after;
        wb_nxt      = begin_after;
        trail_nxt   = open_after ? trail_after : 16'd0;
        ovf_nxt     = ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd0;
      in_word_r <= 1'b0;
      wb_r      <= 16'd0;
      trail_r   <= 16'd0;
      ovf_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      in_word_r <= in_word_nxt;
      wb_r      <= wb_nxt;
      trail_r   <= trail_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/wtok_queue.sv
`default_nettype none
module wtok_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wtok_pkg::job_t push_job,
  output logic                full,
  output logic                head_valid,
  output wtok_pkg::job_t      head_job,
  input  wire logic           pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wtok_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/wtok_back.sv
`default_nettype none
module wtok_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire wtok_pkg::job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_token_kind,
  output logic [15:0]         out_token_offset,
  output logic [15:0]         out_token_length,
  output logic                out_text_done,
  output logic                out_offset_overflow,
  output logic                out_run_last
);

  // Bit 0 word, bit 1 apostrophe run, bit 2 single-byte token.
  logic [2:0]  taken_r, taken_nxt;
  logic [2:0]  remain, cur;
  logic        last, load;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] off_r, off_nxt, len_r, len_nxt;
  logic        done_r, ovf_r, last_r;

  always_comb begin
    remain = {head_job.single_valid, head_job.run_valid, head_job.word_valid} & ~taken_r;
    cur    = remain & (~remain + 3'd1);
    last   = (remain & ~cur) == 3'd0;
    load   = head_valid && (!out_valid_r || out_ready);
    pop    = load && last;

    kind_nxt = wtok_pkg::KIND_SINGLE;
    off_nxt  = head_job.single_off;
    len_nxt  = 16'd1;
    if (cur[0]) begin
      kind_nxt = wtok_pkg::KIND_WORD;
      off_nxt  = head_job.word_off;
      len_nxt  = head_job.word_len;
    end else if (cur[1]) begin
      kind_nxt = wtok_pkg::KIND_RUN;
      off_nxt  = head_job.run_off;
      len_nxt  = head_job.run_len;
    end

    taken_nxt = taken_r;
    if (load) begin
      taken_nxt = last ? 3'd0 : (taken_r | cur);
    end
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      off_r  <= off_nxt;
      len_r  <= len_nxt;
      done_r <= head_job.done;
      ovf_r  <= head_job.ovf;
      last_r <= last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_token_kind      = kind_r;
  assign out_token_offset    = off_r;
  assign out_token_length    = len_r;
  assign out_text_done       = done_r;
  assign out_offset_overflow = ovf_r;
  assign out_run_last        = last_r;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog ends the run after this many cycles without a single transfer
  // on either channel. The longest legal quiet stretch is a few stalls in a row
  // plus the pipeline delay, which is far below this.
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles to keep watching after the last expected token, so that a stray
  // extra token shows up as a failure.
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_BYTES   = 450;

  // One token as it appears on the result channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic        done;
    logic        ovf;
    logic        last;
  } token_t;

  // Tokenizer state machine kept beside the block. Every accepted byte is run
  // through it, and the tokens it yields are queued in order; every token seen
  // on the result channel must match the head of that queue.
  class token_scoreboard;
    token_t      pending[$];
    token_t      step_tokens[$];
    int          errors;
    logic [15:0] position;
    logic        in_word;
    logic [15:0] word_begin;
    logic [15:0] trailing;
    logic        overflowed;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      position   = '0;
      in_word    = 1'b0;
      word_begin = '0;
      trailing   = '0;
      overflowed = 1'b0;
    endfunction

    static function bit is_skip(logic [7:0] b);
      return b <= wtok_pkg::BYTE_SPACE || b == wtok_pkg::BYTE_DEL;
    endfunction

    static function bit is_word_byte(logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
             (b >= 8'h30 && b <= 8'h39) || b >= wtok_pkg::BYTE_HIGH;
    endfunction

    function void add_token(logic [1:0] kind, int unsigned off, int unsigned len,
                            logic done);
      token_t t;
      t.kind   = kind;
      t.offset = off[15:0];
      t.length = (len > 32'hffff) ? 16'hffff : len[15:0];
      t.done   = done;
      t.ovf    = overflowed;
      t.last   = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
    endfunction

    // Closes the open word whose region ends just before stop_off. Trailing
    // apostrophes are split off as a run, but the word always keeps a byte.
    function void close_word(int unsigned stop_off, logic done);
      int unsigned span;
      int unsigned tr;
      span = (stop_off > word_begin) ? stop_off - word_begin : 1;
      tr   = trailing;
      if (tr > span - 1) tr = span - 1;
      add_token(wtok_pkg::KIND_WORD, word_begin, span - tr, done);
      if (tr > 0) add_token(wtok_pkg::KIND_RUN, word_begin + span - tr, tr, done);
      in_word  = 1'b0;
      trailing = '0;
    endfunction

    function void absorb_byte(logic [7:0] b, logic fin);
      int unsigned p;
      step_tokens.delete();
      p = position;
      if (p > wtok_pkg::OFFSET_CAP) p = wtok_pkg::OFFSET_CAP;
      // At the cap the counter cannot move, and the overflow flag is raised
      // in time to show on this byte's own tokens.
      if (p < wtok_pkg::OFFSET_CAP) position = 16'(p + 1);
      else overflowed = 1'b1;

      if (in_word) begin
        if (is_word_byte(b)) begin
          trailing = '0;
        end else if (b == wtok_pkg::BYTE_APOS) begin
          if (trailing < 16'hffff) trailing = trailing + 16'd1;
        end else begin
          close_word(p, fin);
          if (!is_skip(b)) add_token(wtok_pkg::KIND_SINGLE, p, 1, fin);
        end
      end else if (is_skip(b)) begin
        // Nothing to report.
      end else if (is_word_byte(b)) begin
        in_word    = 1'b1;
        word_begin = p[15:0];
        trailing   = '0;
      end else begin
        add_token(wtok_pkg::KIND_SINGLE, p, 1, fin);
      end

      if (fin) begin
        if (in_word) close_word(p + 1, fin);
        clear();
      end
      foreach (step_tokens[i]) begin
        if (i == step_tokens.size() - 1) step_tokens[i].last = 1'b1;
        pending.insert(pending.size(), step_tokens[i]);
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind=%0d off=%0d len=%0d done=%0b ovf=%0b last=%0b",
                 $time, got.kind, got.offset, got.length, got.done, got.ovf, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch, expected kind=%0d off=%0d len=%0d done=%0b ovf=%0b last=%0b",
                 $time, want.kind, want.offset, want.length, want.done, want.ovf, want.last);
        $display("%0t:           actual   kind=%0d off=%0d len=%0d done=%0b ovf=%0b last=%0b",
                 $time, got.kind, got.offset, got.length, got.done, got.ovf, got.last);
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_text_byte  = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_ready     = 1'b0;
  wire logic        in_ready;
  wire logic        out_valid;
  wire logic [1:0]  out_token_kind;
  wire logic [15:0] out_token_offset;
  wire logic [15:0] out_token_length;
  wire logic        out_text_done;
  wire logic        out_offset_overflow;
  wire logic        out_run_last;

  token_scoreboard board = new();

  // Idle levels for the two sides: 0 means no gaps at all, 1 short gaps only,
  // 2 short gaps with an occasional long one.
  int in_level  = 1;
  int out_level = 1;
  int out_hold  = 0;
  int quiet     = 0;

  word_tokenizer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_kind     (out_token_kind),
    .out_token_offset   (out_token_offset),
    .out_token_length   (out_token_length),
    .out_text_done      (out_text_done),
    .out_offset_overflow(out_offset_overflow),
    .out_run_last       (out_run_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(int level);
    int r;
    if (level == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93 || level == 1) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] pick_word_byte();
    case ($urandom_range(0, 3))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return wtok_pkg::BYTE_HIGH + 8'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] pick_skip_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 31));
      1: return wtok_pkg::BYTE_SPACE;
      default: return wtok_pkg::BYTE_DEL;
    endcase
  endfunction

  // Text content is words more than anything else, with apostrophes often enough to form
  // inner and trailing runs, plus blanks, punctuation and raw noise.
  function automatic logic [7:0] pick_text_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 45) return pick_word_byte();
    if (r < 65) return wtok_pkg::BYTE_APOS;
    if (r < 78) return pick_skip_byte();
    if (r < 93) begin
      case ($urandom_range(0, 3))
        0: b = 8'($urandom_range(8'h21, 8'h2f));
        1: b = 8'($urandom_range(8'h3a, 8'h40));
        2: b = 8'($urandom_range(8'h5b, 8'h60));
        default: b = 8'($urandom_range(8'h7b, 8'h7e));
      endcase
      return (b == wtok_pkg::BYTE_APOS) ? 8'h28 : b;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Presents one byte and returns at the edge where it is transferred. The
  // valid line is lowered only when a gap is wanted, so it is never dropped
  // and raised again in the same step.
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = pick_gap(in_level);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every token expected so far has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic directed_bytes();
    send_byte(wtok_pkg::BYTE_APOS, 1'b0);  // An apostrophe outside a word stands alone.
    send_byte(8'h41, 1'b0);                // 'A' opens a word.
    send_byte(wtok_pkg::BYTE_APOS, 1'b0);
    send_byte(8'h7a, 1'b0);                // 'z' makes the apostrophe an inner one.
    send_byte(wtok_pkg::BYTE_APOS, 1'b0);
    send_byte(wtok_pkg::BYTE_APOS, 1'b0);
    send_byte(8'h21, 1'b0);                // '!' gives a word, a run and a single token.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(wtok_pkg::BYTE_HIGH, 1'b0);
    send_byte(wtok_pkg::BYTE_SPACE, 1'b0); // A blank closes the word but gives no token of its own.
    send_byte(8'h30, 1'b0);                // '0'
    send_byte(8'h39, 1'b0);                // '9'
    send_byte(wtok_pkg::BYTE_APOS, 1'b0);
    send_byte(wtok_pkg::BYTE_DEL, 1'b0);   // DEL closes the word and its run.
    send_byte(8'h7e, 1'b0);                // '~'
    send_byte(8'h1f, 1'b0);
    send_byte(8'h61, 1'b0);                // 'a'
    send_byte(wtok_pkg::BYTE_APOS, 1'b1);  // The flush backs the apostrophe out.
    send_byte(8'h5a, 1'b1);                // A one-byte text that is one word.
    send_byte(8'h62, 1'b0);                // 'b'
    send_byte(8'h2f, 1'b1);                // '/' closes the word on the final byte.
    send_byte(wtok_pkg::BYTE_SPACE, 1'b1); // A final blank flushes nothing.
    send_byte(8'h40, 1'b1);                // '@'
    send_byte(8'h60, 1'b1);                // Grave accent.
  endtask

  // The result side stalls in stretches drawn from its idle level.
  always @(posedge clk) begin
    int g;
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      g = pick_gap(out_level);
      if (g > 0) begin
        out_ready <= 1'b0;
        out_hold = g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Both channels are sampled at the rising edge, before any of the values
  // driven at that edge take effect. An input transfer feeds the scoreboard,
  // a result transfer is checked against it, and a long stretch with no
  // transfer at all ends the run.
  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if (in_valid && in_ready) board.absorb_byte(in_text_byte, in_final_byte);
      if (out_valid && out_ready) begin
        got = {out_token_kind, out_token_offset, out_token_length,
               out_text_done, out_offset_overflow, out_run_last};
        board.check_token(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d tokens still expected",
                   $time, quiet, board.pending.size());
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int sent;
    int len;
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_bytes();
    // The sender holds off here until every token so far has arrived.
    wait_drained();

    // Random texts, each with its own idle levels so that some run at full
    // rate on both sides and others stall hard enough to fill the queue.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      in_level  = $urandom_range(0, 2);
      out_level = $urandom_range(0, 2);
      len = $urandom_range(1, 24);
      for (i = 0; i < len; i++) send_byte(pick_text_byte(), i == len - 1);
      sent += len;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
